// ----- rtl/buddy_block_allocator_core_defines.svh -----
// assertion helpers used by the checker
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bba check failed");

// next-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bba check failed");

`endif

// ----- rtl/bba_pkg.sv -----
package bba_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int GRAIN_LG     = 4;
  localparam int LEVEL_COUNT  = 17;
  localparam int SLOT_COUNT   = 4096;
  localparam int SLOT_W       = 12;
  localparam int LINK_W       = 13;
  localparam int LVL_W        = 5;
  localparam int POOL_W       = 17;

  localparam logic [LINK_W-1:0] NIL       = 13'd4096;
  localparam logic [POOL_W-1:0] MAX_POOL  = 17'd65536;
  localparam logic [POOL_W-1:0] MIN_PAY   = 17'd16;
  localparam logic [LVL_W-1:0]  TOP_LVL   = 5'd16;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_REJ = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;

  // one slot record in the slot memory
  typedef struct packed {
    logic              blk;
    logic              taken;
    logic [LVL_W-1:0]  lvl;
    logic [LINK_W-1:0] nxt;
  } slot_word_t;

  // position of the leading one
  function automatic logic [LVL_W-1:0] floor_log2(input logic [POOL_W:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i <= POOL_W; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/bba_ram.sv -----
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/buddy_block_allocator_core.sv -----
// alloc scans the levels for a non-empty free list, pops its head and splits down level by level;
//   free checks and pushes the block, then merges level by level, walking free lists to unlink buddies
// throughput: one item at a time, the slot memory port sets the pace
// reset (rst_n low, synchronous) or a pool write runs a clearing pass
//   over the slot memory, then carves the pool at one block per cycle
// in_ready stays low during clearing and carving
module buddy_block_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_block_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_payload_offset,
  output logic [1:0]  out_status,
  output logic [12:0] out_taken_count,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_CARVE, S_IDLE, S_A_SCAN, S_A_RD, S_A_SPLIT, S_F_CHK, S_M_CHK,
    S_M_BRD, S_U_T, S_U_W, S_U_S, S_M_W1, S_M_W2, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic [POOL_W-1:0] pool_r, pool_nxt, carved_r, carved_nxt, size_r, size_nxt;
  logic [12:0] count_r, count_nxt;
  logic [LINK_W-1:0] head_r [LEVEL_COUNT];
  logic [LINK_W-1:0] head_nxt [LEVEL_COUNT];
  logic [LINK_W-1:0] clr_r, clr_nxt, tnext_r, tnext_nxt, snext_r, snext_nxt;
  logic [LVL_W-1:0] lv_r, lv_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt, b_r, b_nxt, tgt_r, tgt_nxt, w_r, w_nxt;
  logic phase_r, phase_nxt;
  logic [15:0] fin_off_r, fin_off_nxt;
  logic [1:0] fin_st_r, fin_st_nxt;
  logic out_valid_r;
  logic [15:0] out_off_r;
  logic [1:0] out_st_r;
  logic [12:0] out_cnt_r;

  logic ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  slot_word_t ram_wdata, ram_rdata;

  bba_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // scratch values for the sequencer
  logic [POOL_W-1:0] limit, rem, bsize, half;
  logic [LVL_W-1:0] clv;
  logic [POOL_W:0] req_sz, bs2;
  logic [15:0] hdr, boff;
  logic brk;

  assign in_ready           = (state_r == S_IDLE) && !cfg_wr_en;
  assign out_valid          = out_valid_r;
  assign out_payload_offset = out_off_r;
  assign out_status         = out_st_r;
  assign out_taken_count    = out_cnt_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    pool_nxt    = pool_r;
    carved_nxt  = carved_r;
    size_nxt    = size_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    clr_nxt     = clr_r;
    tnext_nxt   = tnext_r;
    snext_nxt   = snext_r;
    lv_nxt      = lv_r;
    s_nxt       = s_r;
    b_nxt       = b_r;
    tgt_nxt     = tgt_r;
    w_nxt       = w_r;
    phase_nxt   = phase_r;
    fin_off_nxt = fin_off_r;
    fin_st_nxt  = fin_st_r;
    ram_we      = 1'b0;
    ram_waddr   = s_r;
    ram_wdata   = '0;
    ram_raddr   = s_r;
    limit       = (pool_r > MAX_POOL) ? MAX_POOL : pool_r;
    rem         = limit - carved_r;
    clv         = floor_log2({1'b0, rem});
    if (clv > TOP_LVL) clv = TOP_LVL;
    bsize       = POOL_W'(1) << clv;
    half        = '0;
    req_sz      = '0;
    bs2         = '0;
    hdr         = in_block_offset - 16'(HEADER_BYTES);
    boff        = '0;
    brk         = 1'b0;

    unique case (state_r)
      // clearing pass over the slot memory
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r[SLOT_W-1:0];
        clr_nxt   = clr_r + 13'd1;
        if (clr_r[SLOT_W-1:0] == '1) begin
          state_nxt  = S_CARVE;
          carved_nxt = '0;
          count_nxt  = '0;
          for (int i = 0; i < LEVEL_COUNT; i++) head_nxt[i] = NIL;
        end
      end
      // greedy carve, one block per cycle
      S_CARVE: begin
        if (carved_r >= limit || bsize < MIN_PAY) begin
          state_nxt = S_IDLE;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = carved_r[GRAIN_LG +: SLOT_W];
          ram_wdata.blk  = 1'b1;
          ram_wdata.lvl  = clv;
          ram_wdata.nxt  = head_r[clv];
          head_nxt[clv]  = {1'b0, carved_r[GRAIN_LG +: SLOT_W]};
          carved_nxt     = carved_r + bsize;
        end
      end
      S_IDLE: begin
        if (cfg_wr_en) begin
          pool_nxt  = cfg_wr_data;
          clr_nxt   = '0;
          state_nxt = S_CLR;
        end else if (in_valid) begin
          if (in_kind == KIND_ALLOC) begin
            size_nxt  = ({1'b0, in_request_size} < MIN_PAY) ? MIN_PAY
                                                             : {1'b0, in_request_size};
            req_sz    = {1'b0, size_nxt} + 18'(HEADER_BYTES);
            lv_nxt    = floor_log2(req_sz) + 5'd1;
            if (req_sz[POOL_W]) lv_nxt = 5'(POOL_W + 1);
            state_nxt = S_A_SCAN;
          end else if (in_block_offset < 16'(HEADER_BYTES) || hdr[GRAIN_LG-1:0] != '0
                       || {1'b0, hdr} >= carved_r) begin
            fin_off_nxt = '0;
            fin_st_nxt  = ST_REJ;
            state_nxt   = S_FIN;
          end else begin
            s_nxt     = hdr[GRAIN_LG +: SLOT_W];
            ram_raddr = hdr[GRAIN_LG +: SLOT_W];
            state_nxt = S_F_CHK;
          end
        end
      end
      // climb to the first non-empty list
      S_A_SCAN: begin
        if (lv_r > TOP_LVL) begin
          fin_off_nxt = '0;
          fin_st_nxt  = ST_OOM;
          state_nxt   = S_FIN;
        end else if (head_r[lv_r] == NIL) begin
          lv_nxt = lv_r + 5'd1;
        end else begin
          s_nxt     = head_r[lv_r][SLOT_W-1:0];
          ram_raddr = head_r[lv_r][SLOT_W-1:0];
          state_nxt = S_A_RD;
        end
      end
      // pop the head
      S_A_RD: begin
        head_nxt[lv_r] = ram_rdata.nxt;
        snext_nxt      = ram_rdata.nxt;
        state_nxt      = S_A_SPLIT;
      end
      // split down, one level per cycle
      S_A_SPLIT: begin
        half = POOL_W'(1) << (lv_r - 5'd1);
        if (lv_r != '0 && {1'b0, half} > {1'b0, size_r} + 18'd32 && half > 17'd32) begin
          ram_we             = 1'b1;
          ram_waddr          = s_r + half[GRAIN_LG +: SLOT_W];
          ram_wdata.blk      = 1'b1;
          ram_wdata.lvl      = lv_r - 5'd1;
          ram_wdata.nxt      = head_r[lv_r - 5'd1];
          head_nxt[lv_r - 5'd1] = {1'b0, s_r + half[GRAIN_LG +: SLOT_W]};
          lv_nxt             = lv_r - 5'd1;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = s_r;
          ram_wdata.blk   = 1'b1;
          ram_wdata.taken = 1'b1;
          ram_wdata.lvl   = lv_r;
          ram_wdata.nxt   = snext_r;
          count_nxt       = count_r + 13'd1;
          fin_off_nxt     = {s_r, 4'd0} + 16'(HEADER_BYTES);
          fin_st_nxt      = ST_OK;
          state_nxt       = S_FIN;
        end
      end
      // check the freed block and push it
      S_F_CHK: begin
        if (!ram_rdata.blk || !ram_rdata.taken) begin
          fin_off_nxt = '0;
          fin_st_nxt  = ST_REJ;
          state_nxt   = S_FIN;
        end else begin
          ram_we                   = 1'b1;
          ram_waddr                = s_r;
          ram_wdata.blk            = 1'b1;
          ram_wdata.lvl            = ram_rdata.lvl;
          ram_wdata.nxt            = head_r[ram_rdata.lvl];
          head_nxt[ram_rdata.lvl]  = {1'b0, s_r};
          lv_nxt                   = ram_rdata.lvl;
          state_nxt                = S_M_CHK;
        end
      end
      // merge bounds and buddy address
      S_M_CHK: begin
        bs2  = 18'(1) << (lv_r + 5'd1);
        boff = {s_r, 4'd0} ^ (16'(1) << lv_r);
        if (lv_r >= TOP_LVL) brk = 1'b1;
        else if (bs2 - 18'(HEADER_BYTES) > {1'b0, carved_r}) brk = 1'b1;
        else if (lv_r < 5'(GRAIN_LG)) brk = 1'b1;
        else if ({1'b0, boff} >= carved_r) brk = 1'b1;
        if (brk) begin
          count_nxt   = count_r - 13'd1;
          fin_off_nxt = '0;
          fin_st_nxt  = ST_OK;
          state_nxt   = S_FIN;
        end else begin
          b_nxt     = boff[GRAIN_LG +: SLOT_W];
          ram_raddr = boff[GRAIN_LG +: SLOT_W];
          state_nxt = S_M_BRD;
        end
      end
      S_M_BRD: begin
        if (!ram_rdata.blk || ram_rdata.lvl != lv_r || ram_rdata.taken) begin
          count_nxt   = count_r - 13'd1;
          fin_off_nxt = '0;
          fin_st_nxt  = ST_OK;
          state_nxt   = S_FIN;
        end else begin
          tgt_nxt   = b_r;
          phase_nxt = 1'b0;
          ram_raddr = b_r;
          state_nxt = S_U_T;
        end
      end
      // unlink target from list lv
      S_U_T: begin
        tnext_nxt = ram_rdata.nxt;
        if (head_r[lv_r] == {1'b0, tgt_r}) begin
          head_nxt[lv_r] = ram_rdata.nxt;
          state_nxt      = phase_r ? S_M_W1 : S_U_S;
        end else if (head_r[lv_r] == NIL) begin
          state_nxt = phase_r ? S_M_W1 : S_U_S;
        end else begin
          w_nxt     = head_r[lv_r][SLOT_W-1:0];
          ram_raddr = head_r[lv_r][SLOT_W-1:0];
          state_nxt = S_U_W;
        end
      end
      S_U_W: begin
        if (ram_rdata.nxt == {1'b0, tgt_r}) begin
          ram_we        = 1'b1;
          ram_waddr     = w_r;
          ram_wdata     = ram_rdata;
          ram_wdata.nxt = tnext_r;
          state_nxt     = phase_r ? S_M_W1 : S_U_S;
        end else if (ram_rdata.nxt == NIL) begin
          state_nxt = phase_r ? S_M_W1 : S_U_S;
        end else begin
          w_nxt     = ram_rdata.nxt[SLOT_W-1:0];
          ram_raddr = ram_rdata.nxt[SLOT_W-1:0];
        end
      end
      S_U_S: begin
        tgt_nxt   = s_r;
        phase_nxt = 1'b1;
        ram_raddr = s_r;
        state_nxt = S_U_T;
      end
      // upper half stops being a block start
      S_M_W1: begin
        ram_we    = 1'b1;
        ram_waddr = (b_r < s_r) ? s_r : b_r;
        state_nxt = S_M_W2;
      end
      // merged block goes on the next list up
      S_M_W2: begin
        ram_we                  = 1'b1;
        ram_waddr               = (b_r < s_r) ? b_r : s_r;
        ram_wdata.blk           = 1'b1;
        ram_wdata.lvl           = lv_r + 5'd1;
        ram_wdata.nxt           = head_r[lv_r + 5'd1];
        head_nxt[lv_r + 5'd1]   = {1'b0, (b_r < s_r) ? b_r : s_r};
        s_nxt                   = (b_r < s_r) ? b_r : s_r;
        lv_nxt                  = lv_r + 5'd1;
        state_nxt               = S_M_CHK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // a pool write while clearing or carving restarts the clearing pass
    if (cfg_wr_en && (state_r == S_CLR || state_r == S_CARVE)) begin
      pool_nxt  = cfg_wr_data;
      clr_nxt   = '0;
      state_nxt = S_CLR;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pool_r      <= MAX_POOL;
      clr_r       <= '0;
      count_r     <= '0;
      carved_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVEL_COUNT; i++) head_r[i] <= NIL;
    end else begin
      state_r  <= state_nxt;
      pool_r   <= pool_nxt;
      clr_r    <= clr_nxt;
      count_r  <= count_nxt;
      carved_r <= carved_nxt;
      head_r   <= head_nxt;
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    size_r    <= size_nxt;
    tnext_r   <= tnext_nxt;
    snext_r   <= snext_nxt;
    lv_r      <= lv_nxt;
    s_r       <= s_nxt;
    b_r       <= b_nxt;
    tgt_r     <= tgt_nxt;
    w_r       <= w_nxt;
    phase_r   <= phase_nxt;
    fin_off_r <= fin_off_nxt;
    fin_st_r  <= fin_st_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_off_r <= fin_off_r;
      out_st_r  <= fin_st_r;
      out_cnt_r <= count_r;
    end
  end

endmodule

// ----- rtl/bba_checker.sv -----
`include "buddy_block_allocator_core_defines.svh"

module bba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_payload_offset,
  input logic [1:0]  out_status,
  input logic [12:0] out_taken_count
);
  import bba_pkg::*;

  // a waiting beat is not dropped
  `BBA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  // one item at a time: busy right after an accepted beat
  `BBA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // failures carry no offset
  `BBA_ASSERT_IMP(a_fail_zero, out_valid && out_status != ST_OK, out_payload_offset == 16'd0)
  // status and count stay in range
  `BBA_ASSERT_IMP(a_ranges, out_valid, out_status <= ST_REJ && out_taken_count <= 13'd4096)

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);
